// ----- design/qppt_pkg.sv -----
// shared types and codes for the queued playout progress tracker
package qppt_pkg;

  localparam logic KIND_SUBMIT   = 1'b0;
  localparam logic KIND_SNAPSHOT = 1'b1;

  localparam logic [2:0] SRC_ESTIMATED = 3'd0;

  localparam logic [1:0] QUAL_EXACT     = 2'd0;
  localparam logic [1:0] QUAL_BOUNDED   = 2'd1;
  localparam logic [1:0] QUAL_ESTIMATED = 2'd2;
  localparam logic [1:0] QUAL_INVALID   = 2'd3;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_GENERATION  = 3'd1,
    ST_TIME_BACK   = 3'd2,
    ST_COUNT_BACK  = 3'd3,
    ST_NOTHING_NEW = 3'd4,
    ST_TOO_LARGE   = 3'd5,
    ST_BAD_QUALITY = 3'd6
  } status_e;

  typedef struct packed {
    logic               kind;
    logic [31:0]        frames;
    logic [31:0]        generation;
    logic [63:0]        backlog;
    logic [63:0]        snap_time_us;
    logic signed [31:0] clk_err_us;
    logic [2:0]         clock_source;
    logic [1:0]         clock_quality;
    logic               underrun;
  } item_t;

  typedef struct packed {
    logic [31:0] expected_generation;
    logic [63:0] submitted_total;
    logic [63:0] reported_total;
    logic [63:0] last_report_time;
    logic        have_report;
  } track_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] delta;
    logic [63:0] consumed;
  } eval_t;

endpackage

// ----- design/qppt_in_stage.sv -----
// input register stage holding one beat
module qppt_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  qppt_pkg::item_t item_i,
  input  logic            advance_i,
  output logic            valid_o,
  output qppt_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  qppt_pkg::item_t item_q, item_d;
  logic            load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/qppt_eval.sv -----
// snapshot checks: consumed count, delta and status
module qppt_eval (
  input  qppt_pkg::item_t  item_i,
  input  qppt_pkg::track_t track_i,
  output qppt_pkg::eval_t  eval_o
);

  logic [64:0] diff_sub;
  logic [63:0] consumed;
  logic [64:0] diff_rep;
  logic        count_back;
  logic        time_back;
  logic        nothing_new;
  logic        too_large;
  logic        src_est;
  logic        qual_est;
  logic        quality_ok;
  logic [31:0] eb;

  assign diff_sub   = {1'b0, track_i.submitted_total} - {1'b0, item_i.backlog};
  // queued count above the total clamps consumed to zero
  assign consumed   = diff_sub[64] ? 64'd0 : diff_sub[63:0];
  assign diff_rep   = {1'b0, consumed} - {1'b0, track_i.reported_total};
  assign count_back = diff_rep[64];
  assign time_back  = track_i.have_report &&
                      (item_i.snap_time_us < track_i.last_report_time);
  assign nothing_new = (diff_rep[63:0] == 64'd0) && !item_i.underrun;
  assign too_large   = |diff_rep[63:32];

  assign eb       = item_i.clk_err_us;
  assign src_est  = (item_i.clock_source == qppt_pkg::SRC_ESTIMATED);
  assign qual_est = (item_i.clock_quality == qppt_pkg::QUAL_ESTIMATED);

  always_comb begin
    quality_ok = 1'b0;
    case (item_i.clock_quality)
      qppt_pkg::QUAL_EXACT:     quality_ok = (eb == 32'd0);
      qppt_pkg::QUAL_BOUNDED:   quality_ok = !eb[31];
      qppt_pkg::QUAL_ESTIMATED: quality_ok = !eb[31] || (eb == 32'hFFFF_FFFF);
      default:                  quality_ok = 1'b0;
    endcase
    if (src_est != qual_est) begin
      quality_ok = 1'b0;
    end
  end

  always_comb begin
    eval_o.delta    = diff_rep[31:0];
    eval_o.consumed = consumed;
    if (item_i.generation != track_i.expected_generation) begin
      eval_o.status = qppt_pkg::ST_GENERATION;
    end else if (time_back) begin
      eval_o.status = qppt_pkg::ST_TIME_BACK;
    end else if (count_back) begin
      eval_o.status = qppt_pkg::ST_COUNT_BACK;
    end else if (nothing_new) begin
      eval_o.status = qppt_pkg::ST_NOTHING_NEW;
    end else if (too_large) begin
      eval_o.status = qppt_pkg::ST_TOO_LARGE;
    end else if (!quality_ok) begin
      eval_o.status = qppt_pkg::ST_BAD_QUALITY;
    end else begin
      eval_o.status = qppt_pkg::ST_ACCEPTED;
    end
  end

endmodule

// ----- design/qppt_state.sv -----
// generation register and running frame counters
module qppt_state (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              submit_i,
  input  logic [31:0]       frames_i,
  input  logic              commit_i,
  input  logic [63:0]       consumed_i,
  input  logic [63:0]       time_i,
  output qppt_pkg::track_t  track_o
);

  qppt_pkg::track_t track_q, track_d;

  always_comb begin
    track_d = track_q;
    if (cfg_we_i) begin
      track_d = '0;
      track_d.expected_generation = cfg_wdata_i;
    end else if (submit_i) begin
      track_d.submitted_total = track_q.submitted_total + {32'd0, frames_i};
    end else if (commit_i) begin
      track_d.reported_total   = consumed_i;
      track_d.last_report_time = time_i;
      track_d.have_report      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_q <= '0;
    end else begin
      track_q <= track_d;
    end
  end

  assign track_o = track_q;

endmodule

// ----- design/queued_playout_progress_tracker_top.sv -----
// top level of the queued playout progress tracker
// One beat is taken per cycle, submits and snapshots alike, for as long as reports
// drain. A beat is first held in the input register; a snapshot then goes through
// the combinational checks and the counter update and lands in the result
// register, from which its report is valid. While a report
// waits on out_ready_i, a snapshot behind it holds in the input register and
// in_ready_o stays low until the report leaves; in_ready_o follows out_ready_i
// combinationally in that case. Submits give no report and only add to the total.
// Writing the generation register clears all counters and takes effect at the next
// edge.
module queued_playout_progress_tracker_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [31:0]        frames_i,
  input  logic [31:0]        generation_i,
  input  logic [63:0]        backlog_i,
  input  logic [63:0]        snap_time_us_i,
  input  logic signed [31:0] clk_err_us_i,
  input  logic [2:0]         clock_source_i,
  input  logic [1:0]         clock_quality_i,
  input  logic               underrun_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [31:0]        frames_played_o,
  output logic [63:0]        report_time_us_o,
  output logic signed [31:0] report_clk_err_us_o,
  output logic [2:0]         report_source_o,
  output logic [1:0]         report_quality_o,
  output logic               report_underrun_o
);

  qppt_pkg::item_t  in_item;
  qppt_pkg::item_t  s1_item;
  qppt_pkg::track_t track;
  qppt_pkg::eval_t  eval;
  logic             s1_valid;
  logic             out_free;
  logic             advance;
  logic             is_snap;
  logic             accepted;

  logic               out_valid_q, out_valid_d;
  qppt_pkg::status_e  status_q, status_d;
  logic [31:0]        played_q, played_d;
  logic [63:0]        time_q, time_d;
  logic signed [31:0] eb_q, eb_d;
  logic [2:0]         src_q, src_d;
  logic [1:0]         qual_q, qual_d;
  logic               ur_q, ur_d;

  always_comb begin
    in_item.kind          = kind_i;
    in_item.frames        = frames_i;
    in_item.generation    = generation_i;
    in_item.backlog       = backlog_i;
    in_item.snap_time_us  = snap_time_us_i;
    in_item.clk_err_us    = clk_err_us_i;
    in_item.clock_source  = clock_source_i;
    in_item.clock_quality = clock_quality_i;
    in_item.underrun      = underrun_i;
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign is_snap  = (s1_item.kind == qppt_pkg::KIND_SNAPSHOT);
  assign advance  = s1_valid && (!is_snap || out_free);
  assign accepted = (eval.status == qppt_pkg::ST_ACCEPTED);

  qppt_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  qppt_eval u_eval (
    .item_i  (s1_item),
    .track_i (track),
    .eval_o  (eval)
  );

  qppt_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .submit_i    (advance && !is_snap),
    .frames_i    (s1_item.frames),
    .commit_i    (advance && is_snap && accepted),
    .consumed_i  (eval.consumed),
    .time_i      (s1_item.snap_time_us),
    .track_o     (track)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    played_d    = played_q;
    time_d      = time_q;
    eb_d        = eb_q;
    src_d       = src_q;
    qual_d      = qual_q;
    ur_d        = ur_q;
    if (advance && is_snap) begin
      out_valid_d = 1'b1;
      status_d    = eval.status;
      played_d    = '0;
      time_d      = '0;
      eb_d        = '0;
      src_d       = '0;
      qual_d      = '0;
      ur_d        = 1'b0;
      if (accepted) begin
        played_d = eval.delta;
        time_d   = s1_item.snap_time_us;
        eb_d     = s1_item.clk_err_us;
        src_d    = s1_item.clock_source;
        qual_d   = s1_item.clock_quality;
        ur_d     = s1_item.underrun;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    played_q <= played_d;
    time_q   <= time_d;
    eb_q     <= eb_d;
    src_q    <= src_d;
    qual_q   <= qual_d;
    ur_q     <= ur_d;
  end

  assign out_valid_o         = out_valid_q;
  assign status_o            = status_q;
  assign frames_played_o     = played_q;
  assign report_time_us_o    = time_q;
  assign report_clk_err_us_o = eb_q;
  assign report_source_o     = src_q;
  assign report_quality_o    = qual_q;
  assign report_underrun_o   = ur_q;

endmodule

// ----- design/qppt_checker.sv -----
// port-level checks on reports, bound to the top level
module qppt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         status_o,
  input logic [31:0]        frames_played_o,
  input logic [63:0]        report_time_us_o,
  input logic signed [31:0] report_clk_err_us_o,
  input logic [2:0]         report_source_o,
  input logic [1:0]         report_quality_o,
  input logic               report_underrun_o
);

  // a stalled report beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
      $stable(frames_played_o) && $stable(report_time_us_o))
    else $error("stalled report changed");

  // rejected reports carry only a status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != qppt_pkg::ST_ACCEPTED) |->
      frames_played_o == 32'd0 && report_time_us_o == 64'd0 &&
      report_clk_err_us_o == 32'sd0 && report_source_o == 3'd0 &&
      report_quality_o == 2'd0 && !report_underrun_o)
    else $error("rejected report has nonzero fields");

  // accepted report with no underrun always plays frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == qppt_pkg::ST_ACCEPTED) && !report_underrun_o |->
      frames_played_o != 32'd0)
    else $error("accepted report with nothing new");

  // accepted clock fields are consistent
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == qppt_pkg::ST_ACCEPTED) |->
      (report_quality_o != qppt_pkg::QUAL_INVALID) &&
      ((report_source_o == qppt_pkg::SRC_ESTIMATED) ==
       (report_quality_o == qppt_pkg::QUAL_ESTIMATED)) &&
      ((report_quality_o != qppt_pkg::QUAL_EXACT) ||
       (report_clk_err_us_o == 32'sd0)))
    else $error("accepted report with bad clock fields");

  // status stays within the defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7)
    else $error("undefined status code");

endmodule

bind queued_playout_progress_tracker_top qppt_checker u_qppt_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .status_o            (status_o),
  .frames_played_o     (frames_played_o),
  .report_time_us_o    (report_time_us_o),
  .report_clk_err_us_o (report_clk_err_us_o),
  .report_source_o     (report_source_o),
  .report_quality_o    (report_quality_o),
  .report_underrun_o   (report_underrun_o)
);

// ----- sim/qppt_report_checker.sv -----
// checker for the playout tracker: predicts report beats and compares what the block returns
module qppt_report_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               kind_i,
  input  logic [31:0]        frames_i,
  input  logic [31:0]        generation_i,
  input  logic [63:0]        backlog_i,
  input  logic [63:0]        snap_time_us_i,
  input  logic signed [31:0] clk_err_us_i,
  input  logic [2:0]         clock_source_i,
  input  logic [1:0]         clock_quality_i,
  input  logic               underrun_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic [31:0]        frames_played_i,
  input  logic [63:0]        report_time_us_i,
  input  logic signed [31:0] report_clk_err_us_i,
  input  logic [2:0]         report_source_i,
  input  logic [1:0]         report_quality_i,
  input  logic               report_underrun_i,
  output int                 mismatches_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    qppt_pkg::status_e  status;
    logic [31:0]        played;
    logic [63:0]        stamp;
    logic signed [31:0] bound;
    logic [2:0]         source;
    logic [1:0]         quality;
    logic               underrun;
  } report_t;

  logic [31:0]     gen_reg;
  logic [63:0]     sub_total;
  logic [63:0]     rep_total;
  logic [63:0]     last_time;
  logic            seen_report;
  report_t         pending_reports[$];
  report_t         got;
  report_t         want;
  qppt_pkg::item_t beat;
  int              errs;

  task automatic wipe_counters();
    sub_total   = '0;
    rep_total   = '0;
    last_time   = '0;
    seen_report = 1'b0;
  endtask

  function automatic logic clock_ok(logic [2:0] src, logic [1:0] q, logic signed [31:0] eb);
    if ((src == qppt_pkg::SRC_ESTIMATED) != (q == qppt_pkg::QUAL_ESTIMATED)) return 1'b0;
    case (q)
      qppt_pkg::QUAL_EXACT:     return eb == 0;
      qppt_pkg::QUAL_BOUNDED:   return eb >= 0;
      qppt_pkg::QUAL_ESTIMATED: return eb >= -1;
      default:                  return 1'b0;
    endcase
  endfunction

  function automatic report_t judge_snapshot(qppt_pkg::item_t b);
    logic [63:0] clamped;
    logic [63:0] consumed;
    logic [63:0] delta;
    report_t     r;
    clamped  = (b.backlog > sub_total) ? sub_total : b.backlog;
    consumed = sub_total - clamped;
    delta    = (consumed >= rep_total) ? consumed - rep_total : 64'd0;
    r = '0;
    if (b.generation != gen_reg) begin
      r.status = qppt_pkg::ST_GENERATION;
    end else if (seen_report && b.snap_time_us < last_time) begin
      r.status = qppt_pkg::ST_TIME_BACK;
    end else if (consumed < rep_total) begin
      r.status = qppt_pkg::ST_COUNT_BACK;
    end else if (delta == 64'd0 && !b.underrun) begin
      r.status = qppt_pkg::ST_NOTHING_NEW;
    end else if (delta > 64'h0000_0000_FFFF_FFFF) begin
      r.status = qppt_pkg::ST_TOO_LARGE;
    end else if (!clock_ok(b.clock_source, b.clock_quality, b.clk_err_us)) begin
      r.status = qppt_pkg::ST_BAD_QUALITY;
    end else begin
      r.status    = qppt_pkg::ST_ACCEPTED;
      r.played    = delta[31:0];
      r.stamp     = b.snap_time_us;
      r.bound     = b.clk_err_us;
      r.source    = b.clock_source;
      r.quality   = b.clock_quality;
      r.underrun  = b.underrun;
      rep_total   = consumed;
      last_time   = b.snap_time_us;
      seen_report = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_reg = '0;
      wipe_counters();
      pending_reports.delete();
      errs = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        gen_reg = cfg_wdata_i;
        wipe_counters();
      end
      // result side first so a beat never meets its own expectation
      if (out_valid_i && out_ready_i) begin
        got = {status_i, frames_played_i, report_time_us_i, report_clk_err_us_i,
               report_source_i, report_quality_i, report_underrun_i};
        if (pending_reports.size() == 0) begin
          if (errs < 10) $display("%0t: report beat with none expected, st=%0d", $time, status_i);
          errs++;
        end else begin
          want = pending_reports.pop_front();
          if (got !== want) begin
            if (errs < 10)
              $display("%0t: report mismatch, expected st=%0d played=%0d t=%h eb=%0d ",
                       $time, want.status, want.played, want.stamp, want.bound,
                       "src=%0d q=%0d ur=%0d, ", want.source, want.quality, want.underrun,
                       "got st=%0d played=%0d t=%h eb=%0d ", got.status, got.played,
                       got.stamp, got.bound,
                       "src=%0d q=%0d ur=%0d", got.source, got.quality, got.underrun);
            errs++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        beat.kind          = kind_i;
        beat.frames        = frames_i;
        beat.generation    = generation_i;
        beat.backlog       = backlog_i;
        beat.snap_time_us  = snap_time_us_i;
        beat.clk_err_us    = clk_err_us_i;
        beat.clock_source  = clock_source_i;
        beat.clock_quality = clock_quality_i;
        beat.underrun      = underrun_i;
        if (beat.kind == qppt_pkg::KIND_SUBMIT) begin
          sub_total = sub_total + 64'(beat.frames);
        end else begin
          pending_reports.push_back(judge_snapshot(beat));
        end
      end
      mismatches_o <= errs;
      pending_o    <= pending_reports.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// testbench top for the playout tracker: clock, reset, stimulus and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [31:0]        cfg_wdata_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               kind_i;
  logic [31:0]        frames_i;
  logic [31:0]        generation_i;
  logic [63:0]        backlog_i;
  logic [63:0]        snap_time_us_i;
  logic signed [31:0] clk_err_us_i;
  logic [2:0]         clock_source_i;
  logic [1:0]         clock_quality_i;
  logic               underrun_i;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [2:0]         status_o;
  logic [31:0]        frames_played_o;
  logic [63:0]        report_time_us_o;
  logic signed [31:0] report_clk_err_us_o;
  logic [2:0]         report_source_o;
  logic [1:0]         report_quality_o;
  logic               report_underrun_o;

  int          fails;
  int          pending;
  int          cycles = 0;
  int          hold_n = 0;
  int          pick;
  logic        calm = 1'b0;
  logic [31:0] cur_gen;
  logic [63:0] fed_total;
  logic [63:0] played;
  logic [63:0] clock_us;
  logic [63:0] base;

  queued_playout_progress_tracker_top u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind_i),
    .frames_i            (frames_i),
    .generation_i        (generation_i),
    .backlog_i           (backlog_i),
    .snap_time_us_i      (snap_time_us_i),
    .clk_err_us_i        (clk_err_us_i),
    .clock_source_i      (clock_source_i),
    .clock_quality_i     (clock_quality_i),
    .underrun_i          (underrun_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_o            (status_o),
    .frames_played_o     (frames_played_o),
    .report_time_us_o    (report_time_us_o),
    .report_clk_err_us_o (report_clk_err_us_o),
    .report_source_o     (report_source_o),
    .report_quality_o    (report_quality_o),
    .report_underrun_o   (report_underrun_o)
  );

  qppt_report_checker u_check (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_i          (in_ready_o),
    .kind_i              (kind_i),
    .frames_i            (frames_i),
    .generation_i        (generation_i),
    .backlog_i           (backlog_i),
    .snap_time_us_i      (snap_time_us_i),
    .clk_err_us_i        (clk_err_us_i),
    .clock_source_i      (clock_source_i),
    .clock_quality_i     (clock_quality_i),
    .underrun_i          (underrun_i),
    .out_valid_i         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .status_i            (status_o),
    .frames_played_i     (frames_played_o),
    .report_time_us_i    (report_time_us_o),
    .report_clk_err_us_i (report_clk_err_us_o),
    .report_source_i     (report_source_o),
    .report_quality_i    (report_quality_o),
    .report_underrun_i   (report_underrun_o),
    .mismatches_o        (fails),
    .pending_o           (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("queued_playout_progress_tracker_top verification failed");
      $finish;
    end
  end

  // report side backpressure
  always @(posedge clk_i) begin
    if (hold_n > 0) begin
      hold_n      <= hold_n - 1;
      out_ready_i <= 1'b0;
    end else begin
      pick = $urandom_range(0, 99);
      if (calm || pick < 70) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        hold_n      <= (pick < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(input qppt_pkg::item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i          <= it.kind;
    frames_i        <= it.frames;
    generation_i    <= it.generation;
    backlog_i       <= it.backlog;
    snap_time_us_i  <= it.snap_time_us;
    clk_err_us_i    <= it.clk_err_us;
    clock_source_i  <= it.clock_source;
    clock_quality_i <= it.clock_quality;
    underrun_i      <= it.underrun;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic feed(input logic [31:0] n);
    qppt_pkg::item_t it;
    it = '0;
    it.kind   = qppt_pkg::KIND_SUBMIT;
    it.frames = n;
    fed_total = fed_total + 64'(n);
    send_item(it);
  endtask

  task automatic snap(input logic [31:0] g, input logic [63:0] qf, input logic [63:0] t,
                      input logic signed [31:0] eb, input logic [2:0] src,
                      input logic [1:0] q, input logic ur);
    qppt_pkg::item_t it;
    it.kind          = qppt_pkg::KIND_SNAPSHOT;
    it.frames        = $urandom;
    it.generation    = g;
    it.backlog       = qf;
    it.snap_time_us  = t;
    it.clk_err_us    = eb;
    it.clock_source  = src;
    it.clock_quality = q;
    it.underrun      = ur;
    send_item(it);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_generation(input logic [31:0] g);
    settle();
    cfg_wdata_i <= g;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cur_gen   = g;
    fed_total = '0;
    played    = '0;
  endtask

  function automatic qppt_pkg::item_t make_beat();
    qppt_pkg::item_t it;
    logic [63:0]     room;
    logic [63:0]     adv;
    int              r;
    it.kind          = qppt_pkg::KIND_SNAPSHOT;
    it.frames        = $urandom;
    it.generation    = cur_gen;
    it.backlog       = {$urandom, $urandom};
    it.snap_time_us  = {$urandom, $urandom};
    it.clk_err_us    = $urandom;
    it.clock_source  = 3'($urandom_range(0, 7));
    it.clock_quality = 2'($urandom_range(0, 3));
    it.underrun      = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (r < 40) begin
      it.kind = qppt_pkg::KIND_SUBMIT;
      r = $urandom_range(0, 99);
      if (r < 75) it.frames = $urandom_range(0, 2000);
      else if (r < 93) it.frames = $urandom;
      else if (r < 97) it.frames = 32'hFFFF_FFFF;
      else it.frames = 32'h0;
      fed_total = fed_total + 64'(it.frames);
      return it;
    end
    clock_us = clock_us + 64'($urandom_range(0, 4000));
    it.snap_time_us = clock_us;
    room = fed_total - played;
    if ($urandom_range(0, 9) == 0) begin
      adv = room;
    end else begin
      adv = 64'($urandom_range(0, 3000));
      if (adv > room) adv = room;
    end
    played = played + adv;
    it.backlog       = fed_total - played;
    it.underrun      = ($urandom_range(0, 7) == 0);
    it.clock_quality = 2'($urandom_range(0, 2));
    if (it.clock_quality == qppt_pkg::QUAL_ESTIMATED) begin
      it.clock_source = qppt_pkg::SRC_ESTIMATED;
      it.clk_err_us   = ($urandom_range(0, 3) == 0) ? -32'sd1 : 32'($urandom_range(0, 90000));
    end else begin
      it.clock_source = 3'($urandom_range(1, 7));
      it.clk_err_us   = (it.clock_quality == qppt_pkg::QUAL_EXACT) ? 32'sd0 :
                        32'($urandom_range(0, 90000));
    end
    // broken snapshots
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 5))
        0: it.generation = ($urandom_range(0, 1) == 1) ? $urandom :
                           cur_gen ^ (32'd1 << $urandom_range(0, 31));
        1: it.snap_time_us = clock_us - 64'($urandom_range(1, 5000));
        2: it.backlog = {$urandom, $urandom};
        3: it.backlog = it.backlog + 64'($urandom_range(1, 400));
        4: begin
          it.clock_source  = 3'($urandom_range(0, 7));
          it.clock_quality = 2'($urandom_range(0, 3));
          it.clk_err_us    = $urandom;
        end
        default: begin
          it.clock_source  = 3'($urandom_range(0, 7));
          it.clock_quality = 2'($urandom_range(0, 3));
          it.clk_err_us    = 32'($urandom_range(0, 3)) - 32'sd2;
        end
      endcase
    end
    return it;
  endfunction

  initial begin
    logic [31:0] g;
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= '0;
    in_valid_i      <= 1'b0;
    kind_i          <= qppt_pkg::KIND_SUBMIT;
    frames_i        <= '0;
    generation_i    <= '0;
    backlog_i       <= '0;
    snap_time_us_i  <= '0;
    clk_err_us_i    <= '0;
    clock_source_i  <= '0;
    clock_quality_i <= '0;
    underrun_i      <= 1'b0;
    cur_gen   = '0;
    fed_total = '0;
    played    = '0;
    clock_us  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed beats on the reset generation
    snap(32'h0, 64'd0, 64'd10, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    snap(32'hFFFF_FFFF, 64'd0, 64'd10, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    snap(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd100, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b1);
    feed(32'hFFFF_FFFF);
    feed(32'hFFFF_FFFF);
    snap(32'h0, 64'd0, 64'd200, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    snap(32'h0, fed_total, 64'd200, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    snap(32'h0, fed_total - 64'hFFFF_FFFF, 64'd200, -32'sd1, qppt_pkg::SRC_ESTIMATED,
         qppt_pkg::QUAL_ESTIMATED, 1'b0);
    snap(32'h0, 64'd0, 64'd50, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    snap(32'h0, fed_total, 64'd300, 32'sd0, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    feed(32'h0);
    feed(32'd20);
    base = fed_total - 64'hFFFF_FFFF;
    snap(32'h0, base - 64'd3, 64'd200, 32'sd0, qppt_pkg::SRC_ESTIMATED, qppt_pkg::QUAL_EXACT,
         1'b0);
    snap(32'h0, base - 64'd3, 64'd200, 32'sd0, 3'd1, qppt_pkg::QUAL_ESTIMATED, 1'b0);
    snap(32'h0, base - 64'd3, 64'd200, 32'sd0, 3'd1, qppt_pkg::QUAL_INVALID, 1'b0);
    snap(32'h0, base - 64'd3, 64'd200, 32'sd1, 3'd1, qppt_pkg::QUAL_EXACT, 1'b0);
    snap(32'h0, base - 64'd3, 64'd200, -32'sd1, 3'd2, qppt_pkg::QUAL_BOUNDED, 1'b0);
    snap(32'h0, base - 64'd3, 64'd200, -32'sd2, qppt_pkg::SRC_ESTIMATED,
         qppt_pkg::QUAL_ESTIMATED, 1'b0);
    snap(32'h0, base - 64'd3, 64'd200, 32'sh7FFF_FFFF, qppt_pkg::SRC_ESTIMATED,
         qppt_pkg::QUAL_ESTIMATED, 1'b0);
    snap(32'h0, base - 64'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 3'd7, qppt_pkg::QUAL_BOUNDED,
         1'b1);
    snap(32'h0, base - 64'd10, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh8000_0000, 3'd3,
         qppt_pkg::QUAL_BOUNDED, 1'b0);
    snap(32'h1, base - 64'd10, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 3'd3, qppt_pkg::QUAL_BOUNDED,
         1'b0);
    snap(32'h0, base - 64'd8, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd0, 3'd3, qppt_pkg::QUAL_BOUNDED,
         1'b0);

    for (int p = 0; p < 5; p++) begin
      g = (p == 0) ? 32'hFFFF_FFFF : (p == 2) ? 32'h0 : $urandom;
      set_generation(g);
      clock_us = p[0] ? {$urandom, $urandom} : 64'd0;
      for (int k = 0; k < 270; k++) begin
        calm <= (p == 2 && k < 80);
        if (p == 3 && k == 135) settle();
        send_item(make_beat());
      end
    end

    settle();
    if (fails == 0) begin
      $display("queued_playout_progress_tracker_top verification clean");
    end else begin
      $display("queued_playout_progress_tracker_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/qppt_pkg.sv
design/qppt_in_stage.sv
design/qppt_eval.sv
design/qppt_state.sv
design/queued_playout_progress_tracker_top.sv
design/qppt_checker.sv
sim/qppt_report_checker.sv
sim/tb_top.sv
